// ----- src/rmq_pkg.sv -----
// ----------------------------------------------------------------------------
// rmq_pkg
// shared types and constants for the rotation matrix to quaternion block
// ----------------------------------------------------------------------------
package rmq_pkg;

  // default sample width, signed fixed point with two integer bits
  localparam int unsigned DataWidthDef = 16;

  // which quaternion component is the pivot
  typedef enum logic [1:0] {
    PIV_W = 2'd0,
    PIV_X = 2'd1,
    PIV_Y = 2'd2,
    PIV_Z = 2'd3
  } pivot_e;

endpackage

// ----- src/rmq_sqrt_pipe.sv -----
// ----------------------------------------------------------------------------
// rmq_sqrt_pipe
// pipelined integer square root, one root bit per stage, with sideband
// ----------------------------------------------------------------------------
module rmq_sqrt_pipe #(
  parameter int unsigned W      = 16,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [2*W-1:0]    rad_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [W-1:0]      root_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int unsigned RW = W + 3;

  logic [W-1:0]      vld_q;
  logic [2*W-1:0]    rad_q  [W];
  logic [RW-1:0]     rem_q  [W];
  logic [W-1:0]      root_q [W];
  logic [SIDE_W-1:0] side_q [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic              vld_p;
    logic [2*W-1:0]    rad_p;
    logic [RW-1:0]     rem_p;
    logic [W-1:0]      root_p;
    logic [SIDE_W-1:0] side_p;
    logic [RW-1:0]     rem_sh;
    logic [RW-1:0]     trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign vld_p  = valid_i;
      assign rad_p  = rad_i;
      assign rem_p  = '0;
      assign root_p = '0;
      assign side_p = side_i;
    end else begin : g_next
      assign vld_p  = vld_q[k-1];
      assign rad_p  = rad_q[k-1];
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign side_p = side_q[k-1];
    end

    // bring down the next two radicand bits and try root*4+1
    assign rem_sh = {rem_p[RW-3:0], rad_p[2*W-1 -: 2]};
    assign trial  = {1'b0, root_p, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= {rad_p[2*W-3:0], 2'b00};
        rem_q[k]  <= ge ? (rem_sh - trial) : rem_sh;
        root_q[k] <= {root_p[W-2:0], ge};
        side_q[k] <= side_p;
      end
    end
  end

  assign valid_o = vld_q[W-1];
  assign root_o  = root_q[W-1];
  assign side_o  = side_q[W-1];

endmodule

// ----- src/rmq_div_pipe.sv -----
// ----------------------------------------------------------------------------
// rmq_div_pipe
// three-lane pipelined restoring divider sharing one divisor, with sideband
// ----------------------------------------------------------------------------
module rmq_div_pipe #(
  parameter int unsigned W      = 16,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [2*W-1:0]    num_i  [3],
  input  logic [W+2:0]      div_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [W-1:0]      quot_o [3],
  output logic [SIDE_W-1:0] side_o
);

  localparam int unsigned RW = W + 3;

  logic [W-1:0]      vld_q;
  logic [W+2:0]      dv_q   [W];
  logic [RW-1:0]     rem_q  [W][3];
  logic [W-1:0]      lo_q   [W][3];
  logic [SIDE_W-1:0] side_q [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic              vld_p;
    logic [W+2:0]      dv_p;
    logic [SIDE_W-1:0] side_p;

    if (k == 0) begin : g_first
      assign vld_p  = valid_i;
      assign dv_p   = div_i;
      assign side_p = side_i;
    end else begin : g_next
      assign vld_p  = vld_q[k-1];
      assign dv_p   = dv_q[k-1];
      assign side_p = side_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_q[k]   <= dv_p;
        side_q[k] <= side_p;
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [RW-1:0] rem_p;
      logic [W-1:0]  lo_p;
      logic [RW-1:0] rem_sh;
      logic          ge;

      if (k == 0) begin : g_first
        assign rem_p = {3'b000, num_i[l][2*W-1:W]};
        assign lo_p  = num_i[l][W-1:0];
      end else begin : g_next
        assign rem_p = rem_q[k-1][l];
        assign lo_p  = lo_q[k-1][l];
      end

      // shift in next dividend bit, quotient bit enters at the bottom
      assign rem_sh = {rem_p[RW-2:0], lo_p[W-1]};
      assign ge     = (rem_sh >= dv_p);

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k][l] <= ge ? (rem_sh - dv_p) : rem_sh;
          lo_q[k][l]  <= {lo_p[W-2:0], ge};
        end
      end
    end
  end

  assign valid_o = vld_q[W-1];
  assign side_o  = side_q[W-1];
  for (genvar l = 0; l < 3; l++) begin : g_out
    assign quot_o[l] = lo_q[W-1][l];
  end

endmodule

// ----- src/rotation_matrix_to_quaternion.sv -----
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// 3x3 rotation matrix to unit quaternion by shepperd's method, pipelined
// ----------------------------------------------------------------------------
// usage
//   input channel: nine signed matrix entries m0..m8 (two integer bits),
//   moved by in_valid_i / in_stall_o; a transfer happens on a clock edge
//   with valid high and stall low
//   output channel: q_scalar, q_x, q_y, q_z in the same format, moved by
//   out_valid_o / out_stall_i
//   throughput: one matrix per cycle, every cycle, when not stalled
//   structure: a register for the trace sums and pivot choice, a square root
//   pipe (one root bit per stage), a division pipe (one quotient bit per
//   stage, three lanes), then sign, saturation and the output register
//   stall: the whole pipe freezes while a result waits at the output and
//   out_stall_i is high; in_stall_o then goes high, nothing is lost or doubled
//   reset: all valid bits clear, the pipe comes up empty and ready
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion #(
  parameter int unsigned DATA_WIDTH = rmq_pkg::DataWidthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [DATA_WIDTH-1:0] m0_i,
  input  logic signed [DATA_WIDTH-1:0] m1_i,
  input  logic signed [DATA_WIDTH-1:0] m2_i,
  input  logic signed [DATA_WIDTH-1:0] m3_i,
  input  logic signed [DATA_WIDTH-1:0] m4_i,
  input  logic signed [DATA_WIDTH-1:0] m5_i,
  input  logic signed [DATA_WIDTH-1:0] m6_i,
  input  logic signed [DATA_WIDTH-1:0] m7_i,
  input  logic signed [DATA_WIDTH-1:0] m8_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [DATA_WIDTH-1:0] q_scalar_o,
  output logic signed [DATA_WIDTH-1:0] q_x_o,
  output logic signed [DATA_WIDTH-1:0] q_y_o,
  output logic signed [DATA_WIDTH-1:0] q_z_o
);

  import rmq_pkg::*;

  localparam int unsigned W    = DATA_WIDTH;
  localparam int unsigned FRAC = W - 2;
  localparam int unsigned SW   = W + 3;             // trace sum width
  localparam int unsigned NW   = W + 1;             // numerator width
  localparam int unsigned SQ_SIDE_W  = 2 + 3 * NW;  // pivot, three numerators
  localparam int unsigned DIV_SIDE_W = 2 + W + 3;   // pivot, p, three signs

  logic out_valid_q;

  // global advance: frozen only while a finished result is held back
  logic adv;
  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  // ---------------- stage 1: trace sums, pivot choice, numerators ----------
  logic signed [SW-1:0] e0, e1, e2, e3, e4, e5, e6, e7, e8;
  logic signed [SW-1:0] one_s;
  logic signed [SW-1:0] s0, s1, s2, s3;
  pivot_e               sel_d;
  logic signed [SW-1:0] ssel;
  logic signed [NW-1:0] n0_d, n1_d, n2_d;

  assign e0 = SW'(m0_i);
  assign e1 = SW'(m1_i);
  assign e2 = SW'(m2_i);
  assign e3 = SW'(m3_i);
  assign e4 = SW'(m4_i);
  assign e5 = SW'(m5_i);
  assign e6 = SW'(m6_i);
  assign e7 = SW'(m7_i);
  assign e8 = SW'(m8_i);
  assign one_s = SW'(1) <<< FRAC;

  assign s0 = one_s + e0 + e4 + e8;
  assign s1 = one_s + e0 - e4 - e8;
  assign s2 = one_s - e0 + e4 - e8;
  assign s3 = one_s - e0 - e4 + e8;

  // strict compares, on a tie the later sum in file order wins
  always_comb begin
    if (s0 > s1 && s0 > s2 && s0 > s3) begin
      sel_d = PIV_W;
    end else if (s1 > s2 && s1 > s3) begin
      sel_d = PIV_X;
    end else if (s2 > s3) begin
      sel_d = PIV_Y;
    end else begin
      sel_d = PIV_Z;
    end
  end

  // numerators in lane order; lane placement is undone at the output
  always_comb begin
    case (sel_d)
      PIV_W: begin
        ssel = s0;
        n0_d = NW'(e5 - e7);
        n1_d = NW'(e6 - e2);
        n2_d = NW'(e1 - e3);
      end
      PIV_X: begin
        ssel = s1;
        n0_d = NW'(e5 - e7);
        n1_d = NW'(e1 + e3);
        n2_d = NW'(e2 + e6);
      end
      PIV_Y: begin
        ssel = s2;
        n0_d = NW'(e6 - e2);
        n1_d = NW'(e5 + e7);
        n2_d = NW'(e1 + e3);
      end
      PIV_Z: begin
        ssel = s3;
        n0_d = NW'(e1 - e3);
        n1_d = NW'(e2 + e6);
        n2_d = NW'(e5 + e7);
      end
      default: begin
        ssel = s0;
        n0_d = '0;
        n1_d = '0;
        n2_d = '0;
      end
    endcase
  end

  logic                 st1_vld_q;
  pivot_e               st1_sel_q;
  logic [W:0]           st1_s_q;     // chosen sum, always positive
  logic signed [NW-1:0] st1_n0_q, st1_n1_q, st1_n2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st1_vld_q <= 1'b0;
    end else if (adv) begin
      st1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st1_sel_q <= sel_d;
      st1_s_q   <= ssel[W:0];
      st1_n0_q  <= n0_d;
      st1_n1_q  <= n1_d;
      st1_n2_q  <= n2_d;
    end
  end

  // ---------------- square root of sum scaled by 2^frac --------------------
  logic [2*W-1:0]       rad;
  logic [SQ_SIDE_W-1:0] sq_side_in;
  logic                 sq_vld;
  logic [W-1:0]         sq_root;
  logic [SQ_SIDE_W-1:0] sq_side;

  assign rad        = {1'b0, st1_s_q, {FRAC{1'b0}}};
  assign sq_side_in = {st1_sel_q, st1_n0_q, st1_n1_q, st1_n2_q};

  rmq_sqrt_pipe #(
    .W      (W),
    .SIDE_W (SQ_SIDE_W)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (st1_vld_q),
    .rad_i   (rad),
    .side_i  (sq_side_in),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // ---------------- pivot and divider operands -----------------------------
  logic [W:0]           root_inc;
  logic [W-1:0]         piv;
  logic [W+2:0]         dvsr;
  logic signed [NW-1:0] sn [3];
  logic [W:0]           mag [3];
  logic [2*W-1:0]       dvnd [3];
  logic [2:0]           sgn;
  logic [DIV_SIDE_W-1:0] dv_side_in;

  assign root_inc = {1'b0, sq_root} + (W+1)'(1);
  assign piv      = root_inc[W:1];          // round(sqrt/2)
  assign dvsr     = {piv, 3'b000};          // 2 * (4p), for round to nearest
  assign sn[0]    = sq_side[3*NW-1 -: NW];
  assign sn[1]    = sq_side[2*NW-1 -: NW];
  assign sn[2]    = sq_side[NW-1:0];

  for (genvar l = 0; l < 3; l++) begin : g_oper
    logic [NW-1:0] abs_v;
    // magnitude keeps all NW bits, the most negative sum has no sign bit left
    assign abs_v   = sn[l][NW-1] ? NW'(-sn[l]) : NW'(sn[l]);
    assign mag[l]  = abs_v;
    assign sgn[l]  = sn[l][NW-1];
    // mag * 2^(frac+1) + 4p, divided by 8p
    assign dvnd[l] = {mag[l], {(W-1){1'b0}}} + (2*W)'({piv, 2'b00});
  end

  assign dv_side_in = {sq_side[SQ_SIDE_W-1 -: 2], piv, sgn};

  logic                  dv_vld;
  logic [W-1:0]          quot [3];
  logic [DIV_SIDE_W-1:0] dv_side;

  rmq_div_pipe #(
    .W      (W),
    .SIDE_W (DIV_SIDE_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (sq_vld),
    .num_i   (dvnd),
    .div_i   (dvsr),
    .side_i  (dv_side_in),
    .valid_o (dv_vld),
    .quot_o  (quot),
    .side_o  (dv_side)
  );

  // ---------------- sign, saturation, placement, output register -----------
  pivot_e                 o_sel;
  logic [W-1:0]           o_piv;
  logic signed [W-1:0]    o_p;
  logic signed [W-1:0]    res [3];
  logic signed [W-1:0]    qs_d, qx_d, qy_d, qz_d;

  assign o_sel = pivot_e'(dv_side[DIV_SIDE_W-1 -: 2]);
  assign o_piv = dv_side[W+2:3];
  assign o_p   = o_piv[W-1] ? {1'b0, {(W-1){1'b1}}} : o_piv;

  for (genvar l = 0; l < 3; l++) begin : g_sat
    logic signed [W:0] val;
    assign val = dv_side[l] ? -$signed({1'b0, quot[l]}) : $signed({1'b0, quot[l]});
    always_comb begin
      if (val[W] != val[W-1]) begin
        res[l] = val[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
        res[l] = val[W-1:0];
      end
    end
  end

  always_comb begin
    case (o_sel)
      PIV_W: begin
        qs_d = o_p;    qx_d = res[0]; qy_d = res[1]; qz_d = res[2];
      end
      PIV_X: begin
        qs_d = res[0]; qx_d = o_p;    qy_d = res[1]; qz_d = res[2];
      end
      PIV_Y: begin
        qs_d = res[0]; qx_d = res[2]; qy_d = o_p;    qz_d = res[1];
      end
      PIV_Z: begin
        qs_d = res[0]; qx_d = res[1]; qy_d = res[2]; qz_d = o_p;
      end
      default: begin
        qs_d = o_p;    qx_d = res[0]; qy_d = res[1]; qz_d = res[2];
      end
    endcase
  end

  logic signed [W-1:0] qs_q, qx_q, qy_q, qz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      qs_q <= qs_d;
      qx_q <= qx_d;
      qy_q <= qy_d;
      qz_q <= qz_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign q_scalar_o  = qs_q;
  assign q_x_o       = qx_q;
  assign q_y_o       = qy_q;
  assign q_z_o       = qz_q;

endmodule
